>>> src/imu_stat_pkg.sv
// Package for the IMU sample statistics block: transaction payload types,
// opcode and statistic select codes, reset constants. No dependencies.
package imu_stat_pkg;

   localparam int unsigned TIME_BITS   = 63;
   localparam int unsigned GAP_BITS    = 40;
   localparam int unsigned SEL_BITS    = 4;
   localparam int unsigned DATA_BITS   = 64;
   localparam int unsigned SAMPLE_BITS = 16;

   localparam logic [GAP_BITS-1:0]  GAP_RESET      = 40'd20000000;
   localparam logic [DATA_BITS-1:0] STEP_MIN_RESET = 64'd1000000000000000;
   localparam logic [DATA_BITS-1:0] S64_MAX        = {1'b0, {63{1'b1}}};
   localparam logic [DATA_BITS-1:0] S64_MIN        = {1'b1, {63{1'b0}}};

   // opcodes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // statistic select codes
   localparam logic [SEL_BITS-1:0] SEL_COUNT    = 4'd0;
   localparam logic [SEL_BITS-1:0] SEL_ACC_X    = 4'd1;
   localparam logic [SEL_BITS-1:0] SEL_ACC_Y    = 4'd2;
   localparam logic [SEL_BITS-1:0] SEL_ACC_Z    = 4'd3;
   localparam logic [SEL_BITS-1:0] SEL_GYR_X    = 4'd4;
   localparam logic [SEL_BITS-1:0] SEL_GYR_Y    = 4'd5;
   localparam logic [SEL_BITS-1:0] SEL_GYR_Z    = 4'd6;
   localparam logic [SEL_BITS-1:0] SEL_ACC_NORM = 4'd7;
   localparam logic [SEL_BITS-1:0] SEL_GYR_NORM = 4'd8;
   localparam logic [SEL_BITS-1:0] SEL_STEP_CNT = 4'd9;
   localparam logic [SEL_BITS-1:0] SEL_STEP_SUM = 4'd10;
   localparam logic [SEL_BITS-1:0] SEL_STEP_MIN = 4'd11;
   localparam logic [SEL_BITS-1:0] SEL_STEP_MAX = 4'd12;
   localparam logic [SEL_BITS-1:0] SEL_NONMONO  = 4'd13;
   localparam logic [SEL_BITS-1:0] SEL_GAP_CNT  = 4'd14;

   typedef struct packed {
      logic                          opcode;
      logic [SEL_BITS-1:0]           stat_select;
      logic [TIME_BITS-1:0]          timestamp_ns;
      logic signed [SAMPLE_BITS-1:0] accel_x;
      logic signed [SAMPLE_BITS-1:0] accel_y;
      logic signed [SAMPLE_BITS-1:0] accel_z;
      logic signed [SAMPLE_BITS-1:0] gyro_x;
      logic signed [SAMPLE_BITS-1:0] gyro_y;
      logic signed [SAMPLE_BITS-1:0] gyro_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] stat_value;
      logic [SEL_BITS-1:0]         stat_echo;
   } rsp_type;

endpackage

>>> src/imu_stat_fifo.sv
// Two-entry request queue between the front and back parts.
// Depends on imu_stat_pkg.
module imu_stat_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  imu_stat_pkg::req_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output imu_stat_pkg::req_type out_data
);

   imu_stat_pkg::req_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

>>> src/imu_stat_isqrt.sv
// Iterative integer square root of an IN_BITS operand, one result bit per
// cycle, IN_BITS/2 root bits. No package dependencies.
module imu_stat_isqrt #(
   parameter int unsigned IN_BITS = 36
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [IN_BITS-1:0]   operand,
   output logic                 done,
   output logic [IN_BITS/2-1:0] root
);

   localparam int unsigned RB = IN_BITS / 2;
   localparam int unsigned CB = $clog2(RB + 1);

   logic [IN_BITS-1:0] rem_ff, rem_in;
   logic [IN_BITS-1:0] res_ff, res_in;
   logic [IN_BITS-1:0] bit_ff, bit_in;
   logic [CB-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [IN_BITS-1:0] trial;

   assign trial = res_ff + bit_ff;
   assign done  = busy_ff && (cnt_ff == CB'(1));
   assign root  = res_in[RB-1:0];

   // one result bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff >> 2;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         cnt_in = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) busy_in = 1'b0;
      end
      if (start) begin
         rem_in  = operand;
         res_in  = '0;
         bit_in  = {2'b01, {(IN_BITS-2){1'b0}}};
         cnt_in  = CB'(RB);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

endmodule

>>> src/imu_stat_back.sv
// Back part: executes queued transactions, holds all statistics, drives the
// result register. Depends on imu_stat_pkg and imu_stat_isqrt.
module imu_stat_back #(
   parameter int unsigned COUNT_BITS  = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  imu_stat_pkg::req_type cmd,
   input  logic [imu_stat_pkg::GAP_BITS-1:0] gap_threshold,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output imu_stat_pkg::rsp_type rsp_data
);

   localparam int unsigned SAMPLE_BITS = imu_stat_pkg::SAMPLE_BITS;
   localparam int unsigned SQ_BITS = 2 * SAMPLE_BITS + 2;
   localparam int unsigned RT_BITS = SQ_BITS / 2;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SQ    = 6'b000010,
      ST_SUMSQ = 6'b000100,
      ST_ROOT  = 6'b001000,
      ST_WAIT  = 6'b010000,
      ST_STEP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]            ax_ff, ax_in;
   logic                  gy_ff, gy_in;
   logic [2*SAMPLE_BITS-1:0] sq_ff;
   logic [SQ_BITS-1:0]    acc_ff;
   logic                  rt_start;
   logic                  rt_done;
   logic [RT_BITS-1:0]    rt_root;

   logic [COUNT_BITS-1:0] sample_count_ff, step_count_ff, nonmono_ff, gap_count_ff;
   logic [63:0] axis_sum_ff [6];
   logic [63:0] acc_norm_ff, gyr_norm_ff;
   logic [63:0] step_sum_ff, step_min_ff, step_max_ff, prev_time_ff;
   logic [63:0] delta_ff;
   logic        rsp_valid_ff;
   imu_stat_pkg::rsp_type rsp_ff;

   logic signed [SAMPLE_BITS-1:0] cur_sample;
   logic signed [SAMPLE_BITS:0]   cur_wide;
   logic [SAMPLE_BITS:0]          cur_mag;
   logic [63:0] t_ext;

   function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
      return (c == CNT_MAX) ? c : c + COUNT_BITS'(1);
   endfunction

   function automatic logic [63:0] sat_u63(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > 65'(imu_stat_pkg::S64_MAX)) ? imu_stat_pkg::S64_MAX : s[63:0];
   endfunction

   function automatic logic [63:0] sat_s64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         s = a[63] ? imu_stat_pkg::S64_MIN : imu_stat_pkg::S64_MAX;
      return s;
   endfunction

   // sample of the axis being squared
   always_comb begin
      case ({gy_ff, ax_ff})
         3'b000:  cur_sample = cmd.accel_x[SAMPLE_BITS-1:0];
         3'b001:  cur_sample = cmd.accel_y[SAMPLE_BITS-1:0];
         3'b010:  cur_sample = cmd.accel_z[SAMPLE_BITS-1:0];
         3'b100:  cur_sample = cmd.gyro_x[SAMPLE_BITS-1:0];
         3'b101:  cur_sample = cmd.gyro_y[SAMPLE_BITS-1:0];
         default: cur_sample = cmd.gyro_z[SAMPLE_BITS-1:0];
      endcase
      cur_wide = {cur_sample[SAMPLE_BITS-1], cur_sample};
      cur_mag  = cur_wide[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-cur_wide)
                                       : (SAMPLE_BITS+1)'(cur_wide);
   end

   assign t_ext     = {1'b0, cmd.timestamp_ns};
   assign rt_start  = (state_ff == ST_SUMSQ) && (ax_ff == 2'd2);
   assign cmd_ready = ((state_ff == ST_IDLE) && cmd_valid && cmd.opcode == imu_stat_pkg::OP_READ
                       && (!rsp_valid_ff || rsp_ready)) || (state_ff == ST_STEP);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   imu_stat_isqrt #(.IN_BITS(SQ_BITS)) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (rt_start),
      .operand (acc_ff + SQ_BITS'(sq_ff)),
      .done    (rt_done),
      .root    (rt_root)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      gy_in    = gy_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ax_in = 2'd0;
            gy_in = 1'b0;
            if (cmd_valid && cmd.opcode == imu_stat_pkg::OP_ADD) state_in = ST_SQ;
         end
         ST_SQ:    state_in = ST_SUMSQ;
         ST_SUMSQ: begin
            if (ax_ff == 2'd2) begin
               state_in = ST_ROOT;
            end else begin
               ax_in = ax_ff + 2'd1;
               state_in = ST_SQ;
            end
         end
         ST_ROOT:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (rt_done) begin
               if (gy_ff) begin
                  state_in = ST_STEP;
               end else begin
                  gy_in = 1'b1;
                  ax_in = 2'd0;
                  state_in = ST_SQ;
               end
            end
         end
         ST_STEP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_SQ) begin
         sq_ff <= (2*SAMPLE_BITS)'(cur_mag) * (2*SAMPLE_BITS)'(cur_mag);
      end
      if (state_ff == ST_SQ && ax_ff == 2'd0) acc_ff <= '0;
      else if (state_ff == ST_SUMSQ) acc_ff <= acc_ff + SQ_BITS'(sq_ff);
      if (state_ff == ST_IDLE) delta_ff <= t_ext - prev_time_ff;
   end

   // statistics and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ax_ff           <= 2'd0;
         gy_ff           <= 1'b0;
         sample_count_ff <= '0;
         step_count_ff   <= '0;
         nonmono_ff      <= '0;
         gap_count_ff    <= '0;
         for (int i = 0; i < 6; i++) axis_sum_ff[i] <= '0;
         acc_norm_ff     <= '0;
         gyr_norm_ff     <= '0;
         step_sum_ff     <= '0;
         step_min_ff     <= imu_stat_pkg::STEP_MIN_RESET;
         step_max_ff     <= '0;
         prev_time_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         gy_ff    <= gy_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         // norm sums
         if (state_ff == ST_WAIT && rt_done) begin
            if (gy_ff) gyr_norm_ff <= sat_u63(gyr_norm_ff, 64'(rt_root));
            else       acc_norm_ff <= sat_u63(acc_norm_ff, 64'(rt_root));
         end
         // read transaction
         if (state_ff == ST_IDLE && cmd_ready) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff.stat_echo <= cmd.stat_select;
            unique case (cmd.stat_select)
               imu_stat_pkg::SEL_COUNT:    rsp_ff.stat_value <= 64'(sample_count_ff);
               imu_stat_pkg::SEL_ACC_X:    rsp_ff.stat_value <= axis_sum_ff[0];
               imu_stat_pkg::SEL_ACC_Y:    rsp_ff.stat_value <= axis_sum_ff[1];
               imu_stat_pkg::SEL_ACC_Z:    rsp_ff.stat_value <= axis_sum_ff[2];
               imu_stat_pkg::SEL_GYR_X:    rsp_ff.stat_value <= axis_sum_ff[3];
               imu_stat_pkg::SEL_GYR_Y:    rsp_ff.stat_value <= axis_sum_ff[4];
               imu_stat_pkg::SEL_GYR_Z:    rsp_ff.stat_value <= axis_sum_ff[5];
               imu_stat_pkg::SEL_ACC_NORM: rsp_ff.stat_value <= acc_norm_ff;
               imu_stat_pkg::SEL_GYR_NORM: rsp_ff.stat_value <= gyr_norm_ff;
               imu_stat_pkg::SEL_STEP_CNT: rsp_ff.stat_value <= 64'(step_count_ff);
               imu_stat_pkg::SEL_STEP_SUM: rsp_ff.stat_value <= step_sum_ff;
               imu_stat_pkg::SEL_STEP_MIN: rsp_ff.stat_value <= step_min_ff;
               imu_stat_pkg::SEL_STEP_MAX: rsp_ff.stat_value <= step_max_ff;
               imu_stat_pkg::SEL_NONMONO:  rsp_ff.stat_value <= 64'(nonmono_ff);
               imu_stat_pkg::SEL_GAP_CNT:  rsp_ff.stat_value <= 64'(gap_count_ff);
               default:                    rsp_ff.stat_value <= '0;
            endcase
         end
         // final commit of an add transaction; axis samples sign-extended
         if (state_ff == ST_STEP) begin
            sample_count_ff <= cnt_inc(sample_count_ff);
            axis_sum_ff[0] <= sat_s64(axis_sum_ff[0],
                                      64'($signed(cmd.accel_x[SAMPLE_BITS-1:0])));
            axis_sum_ff[1] <= sat_s64(axis_sum_ff[1],
                                      64'($signed(cmd.accel_y[SAMPLE_BITS-1:0])));
            axis_sum_ff[2] <= sat_s64(axis_sum_ff[2],
                                      64'($signed(cmd.accel_z[SAMPLE_BITS-1:0])));
            axis_sum_ff[3] <= sat_s64(axis_sum_ff[3],
                                      64'($signed(cmd.gyro_x[SAMPLE_BITS-1:0])));
            axis_sum_ff[4] <= sat_s64(axis_sum_ff[4],
                                      64'($signed(cmd.gyro_y[SAMPLE_BITS-1:0])));
            axis_sum_ff[5] <= sat_s64(axis_sum_ff[5],
                                      64'($signed(cmd.gyro_z[SAMPLE_BITS-1:0])));
            if (prev_time_ff != '0) begin
               if (t_ext <= prev_time_ff) begin
                  nonmono_ff <= cnt_inc(nonmono_ff);
               end else begin
                  step_count_ff <= cnt_inc(step_count_ff);
                  step_sum_ff   <= sat_u63(step_sum_ff, delta_ff);
                  if (delta_ff < step_min_ff) step_min_ff <= delta_ff;
                  if (delta_ff > step_max_ff) step_max_ff <= delta_ff;
                  if (delta_ff > 64'(gap_threshold)) gap_count_ff <= cnt_inc(gap_count_ff);
               end
            end
            prev_time_ff <= t_ext;
         end
      end
   end

endmodule

>>> src/imu_sample_statistics.sv
// A read passes the queue to the back part, which registers its result when
// idle; behind an add it waits until that add has committed. The back part
// takes no request while an add runs two vector norms (accel, then gyro), each
// summing three squared axes, then taking a one-bit-per-cycle square root of
// SAMPLE_BITS+1 bits. One read per cycle while results are taken; 2-entry queue.
// Reset: synchronous, active high; zeroes stats, step min 1e15, threshold 20 ms.
module imu_sample_statistics #(
   parameter int unsigned COUNT_BITS  = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  imu_stat_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output imu_stat_pkg::rsp_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [imu_stat_pkg::GAP_BITS-1:0] csr_data
);

   logic [imu_stat_pkg::GAP_BITS-1:0] gap_ff;
   logic                  q_valid, q_ready;
   imu_stat_pkg::req_type q_data;

   // threshold register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset)          gap_ff <= imu_stat_pkg::GAP_RESET;
      else if (csr_valid) gap_ff <= csr_data;
   end

   imu_stat_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   imu_stat_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd_ready     (q_ready),
      .cmd           (q_data),
      .gap_threshold (gap_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

>>> src/imu_stat_checker.sv
// Port-level checker for imu_sample_statistics, bound to the top level.
// Depends on imu_stat_pkg.
module imu_stat_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input imu_stat_pkg::req_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input imu_stat_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // no result straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // unused select reads zero
   a_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stat_echo == 4'd15 |-> rsp_data.stat_value == '0)
      else $error("unused select gave nonzero");

   // step minimum never negative when read
   a_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stat_echo == imu_stat_pkg::SEL_STEP_MIN
      |-> !rsp_data.stat_value[63])
      else $error("negative step minimum");

endmodule

bind imu_sample_statistics imu_stat_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/sv/imu_sample_statistics_checker.sv
// Checker for the IMU sample statistics block: watches the request, response
// and register write channels, predicts each read and compares. Uses imu_stat_pkg.
`timescale 1ns / 1ps

module imu_sample_statistics_checker
   import imu_stat_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_type             rsp_data,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [GAP_BITS-1:0] csr_data,
   output int                  error_count,
   output int                  pending_reads,
   output int                  reads_checked
);

   localparam logic [63:0] COUNT_LIMIT = {64{1'b1}} >> (64 - COUNT_BITS);

   // mirrored statistics state
   logic [GAP_BITS-1:0] gap_threshold;
   logic [63:0]         n_samples, n_steps, n_nonmono, n_gaps;
   logic signed [63:0]  acc_sum [3];
   logic signed [63:0]  gyr_sum [3];
   logic [63:0]         acc_norm_total, gyr_norm_total;
   logic [63:0]         step_total, step_lo, step_hi, last_time;
   rsp_type             read_queue [$];

   function automatic logic [63:0] bump(logic [63:0] c);
      return (c >= COUNT_LIMIT) ? COUNT_LIMIT : c + 64'd1;
   endfunction

   function automatic logic signed [63:0] add_signed_sat(logic signed [63:0] a,
                                                         logic signed [63:0] b);
      logic signed [64:0] s;
      s = a + b;
      if (s > $signed({1'b0, S64_MAX})) return S64_MAX;
      if (s < $signed({1'b1, S64_MIN})) return S64_MIN;
      return s[63:0];
   endfunction

   function automatic logic [63:0] add_u63_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, S64_MAX}) ? S64_MAX : s[63:0];
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] vector_norm(logic signed [15:0] x,
                                               logic signed [15:0] y,
                                               logic signed [15:0] z);
      logic signed [63:0] a, b, c;
      a = x;
      b = y;
      c = z;
      return floor_root(a * a + b * b + c * c);
   endfunction

   function automatic logic [63:0] select_stat(logic [SEL_BITS-1:0] s);
      case (s)
         SEL_COUNT:    return n_samples;
         SEL_ACC_X:    return acc_sum[0];
         SEL_ACC_Y:    return acc_sum[1];
         SEL_ACC_Z:    return acc_sum[2];
         SEL_GYR_X:    return gyr_sum[0];
         SEL_GYR_Y:    return gyr_sum[1];
         SEL_GYR_Z:    return gyr_sum[2];
         SEL_ACC_NORM: return acc_norm_total;
         SEL_GYR_NORM: return gyr_norm_total;
         SEL_STEP_CNT: return n_steps;
         SEL_STEP_SUM: return step_total;
         SEL_STEP_MIN: return step_lo;
         SEL_STEP_MAX: return step_hi;
         SEL_NONMONO:  return n_nonmono;
         SEL_GAP_CNT:  return n_gaps;
         default:      return 64'd0;
      endcase
   endfunction

   assign pending_reads = read_queue.size();

   // predict on each accepted transaction, compare each accepted response
   always @(posedge clock) begin
      logic [63:0] t, d;
      rsp_type     want;
      int          errs;
      errs = 0;
      if (reset) begin
         gap_threshold  <= GAP_RESET;
         n_samples      <= 0;
         n_steps        <= 0;
         n_nonmono      <= 0;
         n_gaps         <= 0;
         acc_norm_total <= 0;
         gyr_norm_total <= 0;
         step_total     <= 0;
         step_lo        <= STEP_MIN_RESET;
         step_hi        <= 0;
         last_time      <= 0;
         for (int i = 0; i < 3; i++) begin
            acc_sum[i] <= 0;
            gyr_sum[i] <= 0;
         end
         read_queue.delete();
         error_count   <= 0;
         reads_checked <= 0;
      end else begin
         if (csr_valid && csr_ready) gap_threshold <= csr_data;
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_READ) begin
               want.stat_value = select_stat(req_data.stat_select);
               want.stat_echo  = req_data.stat_select;
               read_queue.push_back(want);
            end else begin
               t = {1'b0, req_data.timestamp_ns};
               n_samples  <= bump(n_samples);
               acc_sum[0] <= add_signed_sat(acc_sum[0], req_data.accel_x);
               acc_sum[1] <= add_signed_sat(acc_sum[1], req_data.accel_y);
               acc_sum[2] <= add_signed_sat(acc_sum[2], req_data.accel_z);
               gyr_sum[0] <= add_signed_sat(gyr_sum[0], req_data.gyro_x);
               gyr_sum[1] <= add_signed_sat(gyr_sum[1], req_data.gyro_y);
               gyr_sum[2] <= add_signed_sat(gyr_sum[2], req_data.gyro_z);
               acc_norm_total <= add_u63_sat(acc_norm_total, vector_norm(
                  req_data.accel_x, req_data.accel_y, req_data.accel_z));
               gyr_norm_total <= add_u63_sat(gyr_norm_total, vector_norm(
                  req_data.gyro_x, req_data.gyro_y, req_data.gyro_z));
               // step evaluation only with a known previous time
               if (last_time != 0) begin
                  if (t <= last_time) begin
                     n_nonmono <= bump(n_nonmono);
                  end else begin
                     d = t - last_time;
                     n_steps    <= bump(n_steps);
                     step_total <= add_u63_sat(step_total, d);
                     if (d < step_lo) step_lo <= d;
                     if (d > step_hi) step_hi <= d;
                     if (d > {24'd0, gap_threshold}) n_gaps <= bump(n_gaps);
                  end
               end
               last_time <= t;
            end
         end
         if (rsp_valid && rsp_ready) begin
            reads_checked <= reads_checked + 1;
            if (read_queue.size() == 0) begin
               $error("unexpected response value=%0h echo=%0d",
                      rsp_data.stat_value, rsp_data.stat_echo);
               errs++;
            end else begin
               want = read_queue.pop_front();
               if (rsp_data.stat_value !== want.stat_value) begin
                  $error("stat_value expected %0h actual %0h",
                         want.stat_value, rsp_data.stat_value);
                  errs++;
               end
               if (rsp_data.stat_echo !== want.stat_echo) begin
                  $error("stat_echo expected %0d actual %0d",
                         want.stat_echo, rsp_data.stat_echo);
                  errs++;
               end
            end
         end
         if (errs != 0) error_count <= error_count + errs;
      end
   end

endmodule

>>> tb/sv/imu_sample_statistics_tb.sv
// Testbench top for the IMU sample statistics block: clock, reset, stimulus,
// register writes and verdict. Depends on imu_stat_pkg and the checker module.
`timescale 1ns / 1ps

module imu_sample_statistics_tb;
   import imu_stat_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [GAP_BITS-1:0] csr_data = '0;
   int                  error_count, pending_reads, reads_checked;
   int                  items_sent = 0;
   bit                  long_stall = 1'b0;
   logic [62:0]         clock_ns = 63'd1000;

   always #10 clock = ~clock;

   imu_sample_statistics u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   imu_sample_statistics_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .error_count(error_count), .pending_reads(pending_reads),
      .reads_checked(reads_checked)
   );

   // receiver stall pattern; a long hold-off when requested
   always @(posedge clock) begin
      if (long_stall) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 20) rsp_ready <= ($urandom_range(0, 3) == 0);
      else rsp_ready <= ($urandom_range(0, 4) != 0);
   end

   initial begin
      #400ms;
      $display("*** FAILED ***");
      $finish;
   end

   // one request transaction; valid stays up until the sender goes idle
   task automatic send(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // sender idle for a number of cycles
   task automatic pause(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic sample(logic [62:0] ts, logic signed [15:0] ax, logic signed [15:0] ay,
                         logic signed [15:0] az, logic signed [15:0] gx,
                         logic signed [15:0] gy, logic signed [15:0] gz);
      req_type r;
      r = '{OP_ADD, 4'($urandom), ts, ax, ay, az, gx, gy, gz};
      send(r);
   endtask

   task automatic read_stat(logic [SEL_BITS-1:0] s);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r.opcode      = OP_READ;
      r.stat_select = s;
      send(r);
   endtask

   task automatic read_all();
      for (int s = 0; s < 16; s++) read_stat(SEL_BITS'(s));
   endtask

   // wait until every read has answered, then let an add finish
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_reads != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_gap(logic [GAP_BITS-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random sample: mostly forward steps, some repeats, jumps back, zeros, random times
   task automatic random_sample();
      int          k;
      logic [62:0] ts;
      k = $urandom_range(0, 99);
      if (k < 70) clock_ns = clock_ns + 63'($urandom_range(1, 40000000));
      else if (k < 78) clock_ns = clock_ns;
      else if (k < 84) clock_ns = clock_ns - 63'($urandom_range(0, 500));
      else if (k < 88) clock_ns = 63'd0;
      else if (k < 94) clock_ns = 63'({$urandom, $urandom});
      else clock_ns = clock_ns + 63'({$urandom_range(0, 255), $urandom});
      ts = clock_ns;
      sample(ts, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int burst;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, unknown time, extremes, non-monotonic, zero time
      read_all();
      sample(63'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000);
      sample(63'd1000, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      sample(63'd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd0);
      sample(63'd500, 16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      sample(63'd30000500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      sample(63'd0, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
      sample({63{1'b1}}, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
      sample(63'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      sample({63{1'b1}}, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      read_all();

      // random phases at several thresholds, extremes included
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_gap('0);
            1: write_gap(40'd1000000000000);
            2: write_gap({GAP_BITS{1'b1}});
            3: write_gap(40'($urandom_range(1, 40000000)));
            default: write_gap(GAP_RESET);
         endcase
         for (int i = 0; i < 200; i++) begin
            if (phase == 1 && i == 40) begin
               // long receiver hold-off while requests keep coming
               long_stall <= 1'b1;
               fork
                  begin repeat (2000) @(posedge clock); long_stall <= 1'b0; end
               join_none
               for (int j = 0; j < 12; j++) read_stat(4'($urandom));
            end
            if (phase == 3 && i == 100) drain();
            burst = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < 30) read_stat(4'($urandom));
            else random_sample();
            if (burst == 0) pause($urandom_range(1, 60));
         end
         read_all();
      end

      req_valid <= 1'b0;
      while (pending_reads != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d request transactions, checked %0d responses over five thresholds.",
               items_sent, reads_checked);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
